// File: hdl/ffca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types, constants and helper functions of the first-fit allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

	localparam int MAX_SEGMENTS = 16;
	localparam int POOL_WORDS   = 1024;
	localparam int SEG_IW       = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
	localparam int WORD_AW      = $clog2(POOL_WORDS);
	localparam int POOL_MAX     = POOL_WORDS * 4;
	localparam int ALU_W        = 15;

	// Request kinds.
	localparam logic [1:0] KIND_INIT  = 2'd0;
	localparam logic [1:0] KIND_ALLOC = 2'd1;
	localparam logic [1:0] KIND_FREE  = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_NOFIT = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_POOL = 1'b0;
	localparam logic CFG_LINE = 1'b1;

	// Shared unit operations.
	localparam logic ALU_ADD = 1'b0;
	localparam logic ALU_SUB = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [12:0] request_size;
		logic        dma_aligned;
		logic [11:0] block_address;
	} in_item_t;

	typedef struct packed {
		logic [11:0] result_address;
		logic [1:0]  status;
	} out_item_t;

	typedef struct packed {
		logic              we_start;
		logic              we_len;
		logic [SEG_IW-1:0] waddr;
		logic [11:0]       wstart;
		logic [12:0]       wlen;
	} seg_wr_t;

	typedef struct packed {
		logic             op;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic [ALU_W-1:0] c;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] sum;
		logic             ge;
		logic             eq;
	} alu_rsp_t;

	// Pool size in use: multiple of 4, clamped to between 16 and the pool size.
	function automatic logic [12:0] eff_pool(input logic [12:0] p);
		logic [12:0] v;
		v = {p[12:2], 2'b00};
		if (v > 13'(POOL_MAX)) v = 13'(POOL_MAX);
		if (v < 13'd16) v = 13'd16;
		return v;
	endfunction

	// Largest power of two not above the value, within 4 to 64.
	function automatic logic [6:0] eff_line(input logic [6:0] v);
		logic [6:0] e;
		if (v >= 7'd64) e = 7'd64;
		else if (v >= 7'd32) e = 7'd32;
		else if (v >= 7'd16) e = 7'd16;
		else if (v >= 7'd8) e = 7'd8;
		else e = 7'd4;
		return e;
	endfunction

endpackage

// File: hdl/first_fit_coalescing_allocator.sv
`timescale 1ns / 1ps
// An allocate walks the segment table for the first fit and either misses, or splits a
// segment or takes a whole one (shifting the later entries down) and then writes the
// header and any padding words. A free scans header words back from the block address,
// then walks the table to merge or insert. One transaction is in work at a time; the
// shared adder sets the pace. Reset and reinitialize run a clearing pass over all
// POOL_WORDS (1024) words of the header store, during which no input transaction is taken.
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator
// First-fit pool allocator with coalescing of free segments.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ffca_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ffca_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [12:0]         cfg_wdata
);
	import ffca_pkg::*;

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_CLEAR  = 5'd1;
	localparam logic [4:0] ST_AS1    = 5'd2;
	localparam logic [4:0] ST_AS2    = 5'd3;
	localparam logic [4:0] ST_AC1    = 5'd4;
	localparam logic [4:0] ST_AC2    = 5'd5;
	localparam logic [4:0] ST_ASPLIT = 5'd6;
	localparam logic [4:0] ST_AADR   = 5'd7;
	localparam logic [4:0] ST_AHDR   = 5'd8;
	localparam logic [4:0] ST_APAD   = 5'd9;
	localparam logic [4:0] ST_SHDN   = 5'd10;
	localparam logic [4:0] ST_FRD    = 5'd11;
	localparam logic [4:0] ST_FCHK   = 5'd12;
	localparam logic [4:0] ST_FFIND  = 5'd13;
	localparam logic [4:0] ST_FM1    = 5'd14;
	localparam logic [4:0] ST_FA1    = 5'd15;
	localparam logic [4:0] ST_FA2    = 5'd16;
	localparam logic [4:0] ST_FA3    = 5'd17;
	localparam logic [4:0] ST_FB     = 5'd18;
	localparam logic [4:0] ST_FB2    = 5'd19;
	localparam logic [4:0] ST_FC     = 5'd20;
	localparam logic [4:0] ST_SHUP   = 5'd21;
	localparam logic [4:0] ST_FCLR   = 5'd22;
	localparam logic [4:0] ST_DONE   = 5'd23;

	logic [4:0]         state_q;
	logic [1:0]         op_q;
	in_item_t           req_q;
	logic [12:0]        pool_q;
	logic [6:0]         line_q;
	logic [ALU_W-1:0]   size_q;
	logic [ALU_W-1:0]   size16_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [12:0]        a_q;
	logic [12:0]        r_q;
	logic [12:0]        newlen_q;
	logic [WORD_AW-1:0] w_q;
	logic [WORD_AW-1:0] clr_q;
	logic [11:0]        prev_s_q;
	logic [12:0]        prev_l_q;
	logic [11:0]        cur_s_q;
	logic [12:0]        cur_l_q;
	out_item_t          res_q;
	out_item_t          out_q;
	logic               out_valid_q;

	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;
	seg_wr_t            seg_wr;
	logic [SEG_IW-1:0]  seg_raddr;
	logic [11:0]        seg_start;
	logic [12:0]        seg_len;
	logic               hdr_we;
	logic [WORD_AW-1:0] hdr_waddr;
	logic [12:0]        hdr_wdata;
	logic [12:0]        hdr_rdata;

	logic [6:0]         line_eff;
	logic [6:0]         align_mask;
	logic [7:0]         extra;
	logic [11:0]        h;
	logic [CNT_W-1:0]   idx_p1;
	logic [CNT_W-1:0]   idx_m1;
	logic [CNT_W-1:0]   i_m1;
	logic               i_lt_n;
	logic               pad_needed;

	ffca_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	ffca_seg_table u_seg (
		.clk    (clk),
		.wr     (seg_wr),
		.raddr  (seg_raddr),
		.rstart (seg_start),
		.rlen   (seg_len)
	);

	ffca_hdr_mem u_hdr (
		.clk   (clk),
		.we    (hdr_we),
		.waddr (hdr_waddr),
		.wdata (hdr_wdata),
		.raddr (w_q),
		.rdata (hdr_rdata)
	);

	// Derived request values.
	assign line_eff   = eff_line(line_q);
	assign align_mask = req_q.dma_aligned ? (line_eff - 7'd1) : 7'd0;
	assign extra      = req_q.dma_aligned ? ({line_eff, 1'b0} + 8'd5) : 8'd7;
	assign h          = {w_q, 2'b00};
	assign idx_p1     = idx_q + 1'b1;
	assign idx_m1     = idx_q - 1'b1;
	assign i_m1       = i_q - 1'b1;
	assign i_lt_n     = (i_q < cnt_q);
	assign pad_needed = ((r_q[6:0] & align_mask) != 7'd0);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Operand selection for the shared unit and write strobes of the stores.
	always_comb begin
		alu_req   = '{op: ALU_ADD, a: '0, b: '0, c: '0};
		seg_wr    = '0;
		seg_wr.waddr = idx_q[SEG_IW-1:0];
		seg_raddr = idx_q[SEG_IW-1:0];
		hdr_we    = 1'b0;
		hdr_waddr = w_q;
		hdr_wdata = 13'd0;
		case (state_q)
			ST_CLEAR: begin
				hdr_we    = 1'b1;
				hdr_waddr = clr_q;
				if (clr_q == WORD_AW'(POOL_WORDS - 1)) begin
					seg_wr.we_start = 1'b1;
					seg_wr.we_len   = 1'b1;
					seg_wr.waddr    = '0;
					seg_wr.wstart   = 12'd0;
					seg_wr.wlen     = eff_pool(pool_q);
				end
			end
			ST_AS1: begin
				alu_req.a = {2'b00, req_q.request_size};
				alu_req.b = {7'd0, extra};
			end
			ST_AS2: begin
				alu_req.a = size_q;
				alu_req.b = ALU_W'(16);
			end
			ST_AC1: begin
				alu_req.a = {2'b00, seg_len};
				alu_req.b = size16_q;
			end
			ST_AC2: begin
				alu_req.a = {2'b00, seg_len};
				alu_req.b = size_q;
			end
			ST_ASPLIT: begin
				alu_req.op    = ALU_SUB;
				alu_req.a     = {2'b00, seg_len};
				alu_req.b     = size_q;
				seg_wr.we_len = 1'b1;
				seg_wr.wlen   = alu_rsp.sum[12:0];
			end
			ST_AADR: begin
				alu_req.a = {3'd0, seg_start};
				alu_req.b = {2'b00, newlen_q};
			end
			ST_AHDR: begin
				alu_req.a = {2'b00, a_q};
				alu_req.b = ALU_W'(4);
				hdr_we    = 1'b1;
				hdr_waddr = a_q[WORD_AW+1:2];
				hdr_wdata = size_q[12:0];
			end
			ST_APAD: begin
				alu_req.a = {2'b00, r_q};
				alu_req.b = ALU_W'(4);
				hdr_we    = pad_needed;
				hdr_waddr = r_q[WORD_AW+1:2];
			end
			ST_SHDN: begin
				seg_raddr = idx_p1[SEG_IW-1:0];
				if (idx_p1 < cnt_q) begin
					seg_wr.we_start = 1'b1;
					seg_wr.we_len   = 1'b1;
					seg_wr.wstart   = seg_start;
					seg_wr.wlen     = seg_len;
				end
			end
			ST_FFIND: begin
				alu_req.a = {3'd0, h};
				alu_req.b = {3'd0, seg_start};
			end
			ST_FM1: begin
				alu_req.a = {3'd0, prev_s_q};
				alu_req.b = {2'b00, prev_l_q};
				alu_req.c = {3'd0, h};
			end
			ST_FA1: begin
				alu_req.a = {2'b00, prev_l_q};
				alu_req.b = size_q;
			end
			ST_FA2: begin
				alu_req.a = {3'd0, prev_s_q};
				alu_req.b = {2'b00, newlen_q};
				alu_req.c = {3'd0, cur_s_q};
				if (!(i_lt_n && alu_rsp.eq)) begin
					seg_wr.we_len = 1'b1;
					seg_wr.waddr  = i_m1[SEG_IW-1:0];
					seg_wr.wlen   = newlen_q;
				end
			end
			ST_FA3: begin
				alu_req.a     = {2'b00, newlen_q};
				alu_req.b     = {2'b00, cur_l_q};
				seg_wr.we_len = 1'b1;
				seg_wr.waddr  = i_m1[SEG_IW-1:0];
				seg_wr.wlen   = alu_rsp.sum[12:0];
			end
			ST_FB: begin
				alu_req.a = {3'd0, h};
				alu_req.b = size_q;
				alu_req.c = {3'd0, cur_s_q};
				if (i_lt_n && alu_rsp.eq) begin
					seg_wr.we_start = 1'b1;
					seg_wr.waddr    = i_q[SEG_IW-1:0];
					seg_wr.wstart   = h;
				end
			end
			ST_FB2: begin
				alu_req.a     = {2'b00, cur_l_q};
				alu_req.b     = size_q;
				seg_wr.we_len = 1'b1;
				seg_wr.waddr  = i_q[SEG_IW-1:0];
				seg_wr.wlen   = alu_rsp.sum[12:0];
			end
			ST_SHUP: begin
				seg_raddr       = idx_m1[SEG_IW-1:0];
				seg_wr.we_start = 1'b1;
				seg_wr.we_len   = 1'b1;
				if (idx_q > i_q) begin
					seg_wr.wstart = seg_start;
					seg_wr.wlen   = seg_len;
				end else begin
					seg_wr.waddr  = i_q[SEG_IW-1:0];
					seg_wr.wstart = h;
					seg_wr.wlen   = size_q[12:0];
				end
			end
			ST_FCLR: begin
				hdr_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= 13'd4096;
			line_q <= 7'd32;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_POOL: pool_q <= cfg_wdata;
				CFG_LINE: line_q <= cfg_wdata[6:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			op_q        <= KIND_NONE;
			clr_q       <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			i_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The finishing state handles the output register by itself.
			if (out_valid_q && out_ready && state_q != ST_DONE) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q  <= in_data.kind;
						idx_q <= '0;
						case (in_data.kind)
							KIND_INIT: begin
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							KIND_ALLOC: state_q <= ST_AS1;
							KIND_FREE: begin
								if (in_data.block_address[11:2] == 10'd0) state_q <= ST_DONE;
								else state_q <= ST_FRD;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == WORD_AW'(POOL_WORDS - 1)) begin
						cnt_q   <= CNT_W'(1);
						state_q <= (op_q == KIND_INIT) ? ST_DONE : ST_IDLE;
					end
				end
				ST_AS1: state_q <= ST_AS2;
				ST_AS2: state_q <= ST_AC1;
				ST_AC1: begin
					if (idx_q == cnt_q) state_q <= ST_DONE;
					else if (alu_rsp.ge) state_q <= ST_ASPLIT;
					else state_q <= ST_AC2;
				end
				ST_AC2: begin
					if (alu_rsp.ge) begin
						state_q <= ST_SHDN;
					end else begin
						idx_q   <= idx_p1;
						state_q <= ST_AC1;
					end
				end
				ST_ASPLIT: state_q <= ST_AADR;
				ST_AADR:   state_q <= ST_AHDR;
				ST_AHDR:   state_q <= ST_APAD;
				ST_APAD: begin
					if (!pad_needed) state_q <= ST_DONE;
				end
				ST_SHDN: begin
					if (idx_p1 < cnt_q) begin
						idx_q <= idx_p1;
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= (op_q == KIND_ALLOC) ? ST_AHDR : ST_FCLR;
					end
				end
				ST_FRD: state_q <= ST_FCHK;
				ST_FCHK: begin
					if (hdr_rdata != 13'd0) state_q <= ST_FFIND;
					else if (w_q == '0) state_q <= ST_DONE;
					else state_q <= ST_FRD;
				end
				ST_FFIND: begin
					if (idx_q == cnt_q || !alu_rsp.ge) begin
						i_q     <= idx_q;
						state_q <= ST_FM1;
					end else begin
						idx_q <= idx_p1;
					end
				end
				ST_FM1: begin
					if (i_q != '0 && alu_rsp.eq) state_q <= ST_FA1;
					else state_q <= ST_FB;
				end
				ST_FA1: state_q <= ST_FA2;
				ST_FA2: begin
					if (i_lt_n && alu_rsp.eq) state_q <= ST_FA3;
					else state_q <= ST_FCLR;
				end
				ST_FA3: begin
					idx_q   <= i_q;
					state_q <= ST_SHDN;
				end
				ST_FB: begin
					if (i_lt_n && alu_rsp.eq) state_q <= ST_FB2;
					else state_q <= ST_FC;
				end
				ST_FB2: state_q <= ST_FCLR;
				ST_FC: begin
					if (cnt_q >= CNT_W'(MAX_SEGMENTS)) begin
						state_q <= ST_DONE;
					end else begin
						idx_q   <= cnt_q;
						state_q <= ST_SHUP;
					end
				end
				ST_SHUP: begin
					if (idx_q > i_q) begin
						idx_q <= idx_m1;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_FCLR;
					end
				end
				ST_FCLR: state_q <= ST_DONE;
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q <= in_data;
				res_q <= '{result_address: 12'd0, status: STAT_OK};
				w_q   <= in_data.block_address[11:2] - 10'd1;
			end
			ST_AS1: begin
				if (alu_rsp.sum[ALU_W-1:4] == '0) size_q <= ALU_W'(16);
				else size_q <= {alu_rsp.sum[ALU_W-1:2], 2'b00};
			end
			ST_AS2: size16_q <= alu_rsp.sum;
			ST_AC1: begin
				if (idx_q == cnt_q) res_q.status <= STAT_NOFIT;
			end
			ST_AC2: begin
				if (alu_rsp.ge) begin
					size_q <= {2'b00, seg_len};
					a_q    <= {1'b0, seg_start};
				end
			end
			ST_ASPLIT: newlen_q <= alu_rsp.sum[12:0];
			ST_AADR:   a_q <= alu_rsp.sum[12:0];
			ST_AHDR:   r_q <= alu_rsp.sum[12:0];
			ST_APAD: begin
				if (pad_needed) r_q <= alu_rsp.sum[12:0];
				else res_q.result_address <= r_q[11:0];
			end
			ST_FCHK: begin
				size_q <= {2'b00, hdr_rdata};
				if (hdr_rdata == 13'd0 && w_q != '0) w_q <= w_q - 1'b1;
			end
			ST_FFIND: begin
				if (idx_q == cnt_q || !alu_rsp.ge) begin
					cur_s_q <= seg_start;
					cur_l_q <= seg_len;
				end else begin
					prev_s_q <= seg_start;
					prev_l_q <= seg_len;
				end
			end
			ST_FA1: newlen_q <= alu_rsp.sum[12:0];
			ST_FC: begin
				if (cnt_q >= CNT_W'(MAX_SEGMENTS)) res_q.status <= STAT_FULL;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) out_q <= res_q;
			end
			default: begin
			end
		endcase
	end

	// The table never holds more entries than it has room for.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_W'(MAX_SEGMENTS))
		else $error("segment count above table size");

	// After a transaction is accepted the block is busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a transaction is in work");

	// Alignment padding only ever writes zero words.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APAD && hdr_we) |-> (hdr_wdata == 13'd0))
		else $error("nonzero padding word");

	// A failed request reports address zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != STAT_OK) |-> (out_data.result_address == 12'd0))
		else $error("failed request with nonzero address");

	// A new result is loaded only when the output register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (state_q != ST_IDLE || $stable(out_data)))
		else $error("pending result overwritten");
endmodule

// File: hdl/ffca_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_alu
// Shared add/subtract unit with magnitude and equality compare.
// ----------------------------------------------------------------------------
module ffca_alu (
	input  ffca_pkg::alu_req_t req,
	output ffca_pkg::alu_rsp_t rsp
);
	import ffca_pkg::*;

	// One adder, a compare of the operands, and a compare of the sum.
	always_comb begin
		rsp.sum = (req.op == ALU_SUB) ? (req.a - req.b) : (req.a + req.b);
		rsp.ge  = (req.a >= req.b);
		rsp.eq  = (rsp.sum == req.c);
	end
endmodule

// File: hdl/ffca_hdr_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_hdr_mem
// Header word store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ffca_hdr_mem (
	input  logic                         clk,
	input  logic                         we,
	input  logic [ffca_pkg::WORD_AW-1:0] waddr,
	input  logic [12:0]                  wdata,
	input  logic [ffca_pkg::WORD_AW-1:0] raddr,
	output logic [12:0]                  rdata
);
	import ffca_pkg::*;

	logic [12:0] mem [POOL_WORDS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// File: hdl/ffca_seg_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_seg_table
// Free-segment table: start and length per entry, one read and one write.
// ----------------------------------------------------------------------------
module ffca_seg_table (
	input  logic                        clk,
	input  ffca_pkg::seg_wr_t           wr,
	input  logic [ffca_pkg::SEG_IW-1:0] raddr,
	output logic [11:0]                 rstart,
	output logic [12:0]                 rlen
);
	import ffca_pkg::*;

	logic [11:0] start_q [MAX_SEGMENTS];
	logic [12:0] len_q   [MAX_SEGMENTS];

	// Field-wise write.
	always_ff @(posedge clk) begin
		if (wr.we_start) start_q[wr.waddr] <= wr.wstart;
		if (wr.we_len) len_q[wr.waddr] <= wr.wlen;
	end

	// Read of the addressed entry.
	assign rstart = start_q[raddr];
	assign rlen   = len_q[raddr];
endmodule
